// ===== rtl/kwp_pkg.sv =====
// Package for the KWP2000 frame builder: shared types and fixed constants.
// Depends on nothing; used by every other file of the block but kwp_ifs.
package kwp_pkg;

    // Fixed protocol constants.
    localparam logic [7:0] FMT_BASE    = 8'hC0;
    localparam logic [7:0] SHORT_LIMIT = 8'd64;
    localparam logic [7:0] SRC_RESET   = 8'hF1;
    localparam logic [7:0] TGT_RESET   = 8'h33;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'd1;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        logic       first;   // opens a frame, header goes out first
        logic       close;   // last payload byte, checksum follows
        logic [7:0] len;     // payload length, meaningful when first is set
        logic [7:0] data;    // payload byte
    } item_t;

    // Address bytes used in the header.
    typedef struct packed {
        logic [7:0] source;
        logic [7:0] target;
    } addr_cfg_t;

endpackage

// ===== rtl/kwp_ifs.sv =====
// Valid/ready channel interfaces for the KWP2000 frame builder.
// Self-contained; used by the top level, the front end and the back end.
interface kwp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] payload_length;

    modport source (output valid, output data_byte, output payload_length, input ready);
    modport sink   (input valid, input data_byte, input payload_length, output ready);
endinterface

interface kwp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, output out_byte, output frame_end, input ready);
    modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

// ===== rtl/kwp_frame_builder_top.sv =====
// Top level of the KWP2000 frame builder: configuration registers and the
// front end, item queue and back end. Depends on kwp_pkg, kwp_ifs and all
// kwp_* modules.
//
// Usage: in_ch carries one payload byte per transaction; the first transaction
// of a frame also gives payload_length. out_ch carries one frame byte per
// transaction: format byte, target, source, a length byte when the length is
// 64 or more, the payload, then the checksum with frame_end set.
// A payload length of zero yields a header and checksum, its data byte unused.
// With nothing older queued, an accepted item goes into the queue, then its
// first output byte through the output register onto out_ch. The back end
// sends one byte per cycle unless out_ch stalls; a middle payload item yields
// its data byte, an opening item the header first, a closing item the checksum
// last. The front end takes one item per cycle while the queue (DEPTH entries)
// has room, so input keeps flowing while headers go out.
// When out_ch stalls, the output register holds and the queue fills, after
// which in_ch.ready drops. Reset empties the queue, closes any open frame and
// sets source to 0xF1 and target to 0x33. The cfg port writes register
// cfg_index (0 source, 1 target) with cfg_wdata when cfg_we is high.
module kwp_frame_builder_top #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    kwp_in_if.sink                        in_ch,
    kwp_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [kwp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_wdata
);

    kwp_pkg::addr_cfg_t cfg_reg;
    kwp_pkg::item_t     push_item;
    kwp_pkg::item_t     head;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;

    // Address registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source <= kwp_pkg::SRC_RESET;
            cfg_reg.target <= kwp_pkg::TGT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kwp_pkg::REG_SOURCE: cfg_reg.source <= cfg_wdata;
                kwp_pkg::REG_TARGET: cfg_reg.target <= cfg_wdata;
                default: ;
            endcase
        end
    end

    kwp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .full  (full),
        .push  (push),
        .item  (push_item)
    );

    kwp_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    kwp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .cfg    (cfg_reg),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

// ===== rtl/kwp_front.sv =====
// Front end: accepts input transactions, tracks the open frame and classifies
// each item for the back end. Depends on kwp_pkg and kwp_in_if.
module kwp_front (
    input  logic             clk,
    input  logic             rst_n,
    kwp_in_if.sink           in_ch,
    input  logic             full,
    output logic             push,
    output kwp_pkg::item_t   item
);

    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic       opens;

    // A new item is taken whenever the queue has room.
    assign in_ch.ready = !full;
    assign push        = in_ch.valid && !full;
    assign opens       = (bytes_left_reg == 8'd0);

    // Classify the item and work out the payload count still due.
    always_comb
    begin
        item.first = opens;
        item.len   = in_ch.payload_length;
        item.data  = in_ch.data_byte;
        if (opens)
        begin
            item.close      = (in_ch.payload_length == 8'd1);
            bytes_left_next = (in_ch.payload_length == 8'd0) ? 8'd0
                                                             : in_ch.payload_length - 8'd1;
        end
        else
        begin
            item.close      = (bytes_left_reg == 8'd1);
            bytes_left_next = bytes_left_reg - 8'd1;
        end
    end

    // Count of payload bytes still due in the open frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 8'd0;
        end
        else if (push)
        begin
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

// ===== rtl/kwp_fifo.sv =====
// Short item queue between the front end and the back end.
// Depends on kwp_pkg for the item type.
module kwp_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  kwp_pkg::item_t   push_item,
    input  logic             pop,
    output kwp_pkg::item_t   head,
    output logic             full,
    output logic             empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    kwp_pkg::item_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // The queue is never written when full nor read when empty.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("item queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("item queue read while empty");

endmodule

// ===== rtl/kwp_back.sv =====
// Back end: expands each queued item into frame bytes, keeps the running
// checksum and drives the output register. Depends on kwp_pkg and kwp_out_if.
module kwp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  kwp_pkg::item_t     head,
    input  logic               empty,
    input  kwp_pkg::addr_cfg_t cfg,
    output logic               pop,
    kwp_out_if.source          out_ch
);

    typedef enum logic [2:0] {
        PH_BEGIN,
        PH_FMT,
        PH_TGT,
        PH_SRC,
        PH_LEN,
        PH_DATA,
        PH_SUM
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     cur_phase;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       frame_end_reg;
    logic       advance;
    logic       done;
    logic       long_len;
    logic [7:0] emit_byte;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.frame_end = frame_end_reg;

    // One byte leaves whenever an item waits and the output slot is free.
    assign advance   = !empty && (!out_valid_reg || out_ch.ready);
    assign pop       = advance && done;
    assign long_len  = (head.len >= kwp_pkg::SHORT_LIMIT);
    assign cur_phase = (phase_reg == PH_BEGIN) ? (head.first ? PH_FMT : PH_DATA) : phase_reg;

    // Byte selection and the next step within the current item.
    always_comb
    begin
        emit_byte  = head.data;
        phase_next = PH_BEGIN;
        done       = 1'b0;
        unique case (cur_phase)
            PH_FMT:
            begin
                emit_byte  = long_len ? kwp_pkg::FMT_BASE
                                      : (kwp_pkg::FMT_BASE | head.len);
                phase_next = PH_TGT;
            end
            PH_TGT:
            begin
                emit_byte  = cfg.target;
                phase_next = PH_SRC;
            end
            PH_SRC:
            begin
                emit_byte  = cfg.source;
                if (long_len)
                begin
                    phase_next = PH_LEN;
                end
                else if (head.len == 8'd0)
                begin
                    phase_next = PH_SUM;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_LEN:
            begin
                emit_byte  = head.len;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                emit_byte = head.data;
                if (head.close)
                begin
                    phase_next = PH_SUM;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            PH_SUM:
            begin
                emit_byte = sum_reg;
                done      = 1'b1;
            end
            default:
            begin
                emit_byte = head.data;
                done      = 1'b1;
            end
        endcase
    end

    // Running checksum: restarts on the format byte, clears after the checksum.
    always_comb
    begin
        if (cur_phase == PH_FMT)
        begin
            sum_next = emit_byte;
        end
        else if (cur_phase == PH_SUM)
        begin
            sum_next = 8'd0;
        end
        else
        begin
            sum_next = sum_reg + emit_byte;
        end
    end

    // Sequencer state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BEGIN;
            sum_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'd0;
            frame_end_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= done ? PH_BEGIN : phase_next;
            sum_reg       <= sum_next;
            out_valid_reg <= 1'b1;
            out_byte_reg  <= emit_byte;
            frame_end_reg <= (cur_phase == PH_SUM);
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // An item in progress stays at the head of the queue until it is finished.
    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_BEGIN) |-> !empty)
        else $error("item left the queue before its bytes were sent");

    // A frame end follows a checksum step and leaves the sum cleared; checked where out_valid_reg rises.
    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && frame_end_reg |-> (sum_reg == 8'd0))
        else $error("checksum not cleared after frame end");

endmodule
